@@ rtl/s19d_pkg.sv @@
// types, constants and neighbour offset table for the 19-point stencil block
`timescale 1ns / 1ps

package s19d_pkg;

  localparam int NSLOT       = 19;
  localparam int CENTRE_SLOT = 18;
  localparam int CELL_W      = 15;
  localparam int WADDR_W     = 20;
  localparam int NCHUNK      = 3;

  typedef enum logic [1:0] {
    OP_WVOLT = 2'd0,
    OP_WWGT  = 2'd1,
    OP_COMP  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    K_WVOLT,
    K_WWGT,
    K_COMP,
    K_EDGE
  } kind_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_RUN,
    B_SCALE,
    B_DONE
  } bstate_t;

  typedef struct packed {
    kind_t                kind;
    logic [4:0]           x;
    logic [4:0]           y;
    logic [4:0]           z;
    logic [WADDR_W-1:0]   waddr;
    logic [31:0]          data;
  } cmd_t;

  typedef struct packed {
    logic [4:0] dx;
    logic [4:0] dy;
    logic [4:0] dz;
  } off_t;

  // offsets as 5-bit modular steps; slot 18 is the centre cell
  function automatic off_t nbr_off(input logic [4:0] k);
    off_t o;
    o = '{dx: 5'd0, dy: 5'd0, dz: 5'd0};
    case (k)
      5'd0:  o = '{dx: 5'd1,  dy: 5'd0,  dz: 5'd0};
      5'd1:  o = '{dx: 5'd0,  dy: 5'd1,  dz: 5'd0};
      5'd2:  o = '{dx: 5'd31, dy: 5'd0,  dz: 5'd0};
      5'd3:  o = '{dx: 5'd0,  dy: 5'd31, dz: 5'd0};
      5'd4:  o = '{dx: 5'd1,  dy: 5'd1,  dz: 5'd0};
      5'd5:  o = '{dx: 5'd31, dy: 5'd1,  dz: 5'd0};
      5'd6:  o = '{dx: 5'd31, dy: 5'd31, dz: 5'd0};
      5'd7:  o = '{dx: 5'd1,  dy: 5'd31, dz: 5'd0};
      5'd8:  o = '{dx: 5'd0,  dy: 5'd0,  dz: 5'd1};
      5'd9:  o = '{dx: 5'd0,  dy: 5'd0,  dz: 5'd31};
      5'd10: o = '{dx: 5'd0,  dy: 5'd1,  dz: 5'd1};
      5'd11: o = '{dx: 5'd0,  dy: 5'd1,  dz: 5'd31};
      5'd12: o = '{dx: 5'd0,  dy: 5'd31, dz: 5'd31};
      5'd13: o = '{dx: 5'd0,  dy: 5'd31, dz: 5'd1};
      5'd14: o = '{dx: 5'd1,  dy: 5'd0,  dz: 5'd1};
      5'd15: o = '{dx: 5'd31, dy: 5'd0,  dz: 5'd1};
      5'd16: o = '{dx: 5'd31, dy: 5'd0,  dz: 5'd31};
      5'd17: o = '{dx: 5'd1,  dy: 5'd0,  dz: 5'd31};
      default: o = '{dx: 5'd0, dy: 5'd0, dz: 5'd0};
    endcase
    return o;
  endfunction

endpackage

@@ rtl/s19d_if.sv @@
// command and result channel interfaces
`timescale 1ns / 1ps

interface s19d_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [4:0]  cell_x;
  logic [4:0]  cell_y;
  logic [4:0]  cell_z;
  logic [4:0]  weight_slot;
  logic signed [31:0] data_value;

  modport source (output valid, op, cell_x, cell_y, cell_z, weight_slot, data_value,
                  input ready);
  modport sink (input valid, op, cell_x, cell_y, cell_z, weight_slot, data_value,
                output ready);
endinterface

interface s19d_res_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] dvm;
  logic        edge_error;

  modport source (output valid, dvm, edge_error, input ready);
  modport sink (input valid, dvm, edge_error, output ready);
endinterface

@@ rtl/s19d_front.sv @@
// front end: accepts command transactions, classifies them and forms store addresses
`timescale 1ns / 1ps

module s19d_front #(
  parameter int GRID_DIM = 32
) (
  s19d_cmd_if.sink                cmd,
  input  logic                    clearing,
  input  logic                    q_ready,
  output logic                    q_valid,
  output s19d_pkg::cmd_t          q_data
);

  localparam logic [8:0] GD   = 9'(GRID_DIM);
  localparam logic [8:0] LAST = 9'(GRID_DIM - 1);

  logic [8:0]  ex, ey, ez;
  logic        in_grid, on_edge, keep;
  logic [19:0] c20, c19;

  always_comb begin
    ex = {4'b0, cmd.cell_x};
    ey = {4'b0, cmd.cell_y};
    ez = {4'b0, cmd.cell_z};
    in_grid = (ex < GD) && (ey < GD) && (ez < GD);
    on_edge = (ex == 9'd0) || (ey == 9'd0) || (ez == 9'd0) ||
              (ex >= LAST) || (ey >= LAST) || (ez >= LAST);
    c20 = {5'b0, cmd.cell_x, cmd.cell_y, cmd.cell_z};
    // cell * 19 by shifts and adds
    c19 = (c20 << 4) + (c20 << 1) + c20;

    q_data.x    = cmd.cell_x;
    q_data.y    = cmd.cell_y;
    q_data.z    = cmd.cell_z;
    q_data.data = cmd.data_value;
    q_data.waddr = c19;
    q_data.kind = s19d_pkg::K_WVOLT;
    keep = 1'b0;
    case (cmd.op)
      s19d_pkg::OP_WVOLT: begin
        q_data.kind = s19d_pkg::K_WVOLT;
        keep = in_grid;
      end
      s19d_pkg::OP_WWGT: begin
        q_data.kind  = s19d_pkg::K_WWGT;
        q_data.waddr = c19 + {15'b0, cmd.weight_slot};
        keep = in_grid && (cmd.weight_slot <= 5'(s19d_pkg::CENTRE_SLOT));
      end
      s19d_pkg::OP_COMP: begin
        q_data.kind = on_edge ? s19d_pkg::K_EDGE : s19d_pkg::K_COMP;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase

    // ignored items are taken and dropped here
    cmd.ready = q_ready && !clearing;
    q_valid   = cmd.valid && !clearing && keep;
  end

endmodule

@@ rtl/s19d_cmdq.sv @@
// two-entry command queue between front and back
`timescale 1ns / 1ps

module s19d_cmdq (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  s19d_pkg::cmd_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output s19d_pkg::cmd_t out_data
);

  s19d_pkg::cmd_t slots [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push, pop;

  always_comb begin
    in_ready  = (cnt != 2'd2);
    out_valid = (cnt != 2'd0);
    out_data  = slots[rp];
    push = in_valid && in_ready;
    pop  = out_valid && out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
    if (push) slots[wp] <= in_data;
  end

endmodule

@@ rtl/s19d_back.sv @@
// back end: stores, 19-tap multiply-accumulate sequencer, scaling and saturation
`timescale 1ns / 1ps

module s19d_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  s19d_pkg::cmd_t q_data,
  input  logic [31:0]    scale,
  output logic           clearing,
  s19d_res_if.source     res
);

  localparam int VDEPTH = 1 << s19d_pkg::CELL_W;
  localparam int WDEPTH = VDEPTH * s19d_pkg::NSLOT;

  logic [31:0] vmem [VDEPTH];
  logic [31:0] wmem [WDEPTH];

  s19d_pkg::bstate_t state, state_next;

  logic [s19d_pkg::CELL_W-1:0]  clr_addr;
  logic [4:0]                   cx, cy, cz;
  logic [s19d_pkg::WADDR_W-1:0] wbase;
  logic [4:0]                   k;
  logic                         v1, c1, v2, c2;
  logic signed [31:0]           vrd, wrd;
  logic signed [63:0]           prod;
  logic signed [69:0]           acc;
  logic                         negs, negc, edge_r;
  logic [71:0]                  mag;
  logic [31:0]                  cm;
  logic [1:0]                   sc, ppj;
  logic                         ppv;
  logic [55:0]                  pp;
  logic [103:0]                 ptot;

  logic                         issue, vwe, wwe;
  logic [s19d_pkg::CELL_W-1:0]  vaddr;
  logic [s19d_pkg::WADDR_W-1:0] waddr;
  logic [31:0]                  vwdata;
  s19d_pkg::off_t               off;
  logic [103:0]                 pp_sh;
  logic [55:0]                  qv, q1;
  logic                         frac, neg;
  logic [31:0]                  sat;
  logic [69:0]                  acc_abs;

  always_comb begin
    state_next = state;
    case (state)
      s19d_pkg::B_CLEAR: if (clr_addr == '1) state_next = s19d_pkg::B_IDLE;
      s19d_pkg::B_IDLE: begin
        if (q_valid && q_data.kind == s19d_pkg::K_COMP) state_next = s19d_pkg::B_RUN;
        if (q_valid && q_data.kind == s19d_pkg::K_EDGE) state_next = s19d_pkg::B_DONE;
      end
      s19d_pkg::B_RUN:
        if (k == 5'(s19d_pkg::NSLOT) && !v1 && !v2) state_next = s19d_pkg::B_SCALE;
      s19d_pkg::B_SCALE:
        if (sc == 2'(s19d_pkg::NCHUNK) && !ppv) state_next = s19d_pkg::B_DONE;
      s19d_pkg::B_DONE: if (!res.valid || res.ready) state_next = s19d_pkg::B_IDLE;
      default: state_next = s19d_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_ready  = (state == s19d_pkg::B_IDLE);
    clearing = (state == s19d_pkg::B_CLEAR);
    issue    = (state == s19d_pkg::B_RUN) && (k < 5'(s19d_pkg::NSLOT));
    off      = s19d_pkg::nbr_off(k);
    vwe      = clearing ||
               (q_ready && q_valid && q_data.kind == s19d_pkg::K_WVOLT);
    vwdata   = clearing ? 32'd0 : q_data.data;
    wwe      = q_ready && q_valid && q_data.kind == s19d_pkg::K_WWGT;
    case (state)
      s19d_pkg::B_CLEAR: vaddr = clr_addr;
      s19d_pkg::B_IDLE:  vaddr = {q_data.x, q_data.y, q_data.z};
      default:           vaddr = {cx + off.dx, cy + off.dy, cz + off.dz};
    endcase
    waddr = q_ready ? q_data.waddr : wbase + {15'b0, k};
    acc_abs = acc[69] ? (~acc + 70'd1) : acc;

    case (ppj)
      2'd0:    pp_sh = {48'b0, pp};
      2'd1:    pp_sh = {24'b0, pp, 24'b0};
      default: pp_sh = {pp, 48'b0};
    endcase

    // shift by 48 rounding toward minus infinity: magnitude floored, rounded up when negative, then sign and clamp
    qv   = ptot[103:48];
    frac = |ptot[47:0];
    neg  = (negs != negc) && ((qv != 56'd0) || frac);
    q1   = qv + {55'b0, frac};
    if (neg) begin
      sat = (q1 >= 56'h80000000) ? 32'h80000000 : 32'd0 - q1[31:0];
    end else begin
      sat = (qv > 56'h7fffffff) ? 32'h7fffffff : qv[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (vwe) begin
      vmem[vaddr] <= vwdata;
    end else begin
      vrd <= vmem[vaddr];
    end
  end

  always_ff @(posedge clk) begin
    if (wwe) begin
      wmem[waddr] <= q_data.data;
    end else begin
      wrd <= wmem[waddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= s19d_pkg::B_CLEAR;
      clr_addr  <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      ppv       <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) clr_addr <= clr_addr + 1'b1;

      if (q_ready && q_valid) begin
        cx     <= q_data.x;
        cy     <= q_data.y;
        cz     <= q_data.z;
        wbase  <= q_data.waddr;
        k      <= 5'd0;
        acc    <= '0;
        edge_r <= (q_data.kind == s19d_pkg::K_EDGE);
      end

      // read, multiply, accumulate
      if (issue) k <= k + 5'd1;
      v1 <= issue;
      c1 <= (k == 5'(s19d_pkg::CENTRE_SLOT));
      v2 <= v1;
      c2 <= c1;
      prod <= wrd * vrd;
      if (v2) acc <= c2 ? acc - {{6{prod[63]}}, prod} : acc + {{6{prod[63]}}, prod};

      if (state == s19d_pkg::B_RUN && state_next == s19d_pkg::B_SCALE) begin
        negs <= acc[69];
        mag  <= {2'b0, acc_abs};
        negc <= scale[31];
        cm   <= scale[31] ? 32'd0 - scale : scale;
        sc   <= 2'd0;
        ptot <= '0;
        ppv  <= 1'b0;
      end

      // magnitude times scale in 24-bit slices
      if (state == s19d_pkg::B_SCALE) begin
        if (sc != 2'(s19d_pkg::NCHUNK)) begin
          case (sc)
            2'd0:    pp <= mag[23:0] * cm;
            2'd1:    pp <= mag[47:24] * cm;
            default: pp <= mag[71:48] * cm;
          endcase
          ppj <= sc;
          sc  <= sc + 2'd1;
        end
        ppv <= (sc != 2'(s19d_pkg::NCHUNK));
        if (ppv) ptot <= ptot + pp_sh;
      end

      if (state == s19d_pkg::B_DONE && (!res.valid || res.ready)) begin
        res.valid      <= 1'b1;
        res.dvm        <= edge_r ? 32'sd0 : $signed(sat);
        res.edge_error <= edge_r;
      end else if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/stencil19_diffusion_update.sv @@
// top level of the 19-point anisotropic diffusion stencil block
//
//   channel  dir  handshake          payload
//   cmd      in   valid/ready        op, cell_x, cell_y, cell_z, weight_slot, data_value
//   res      out  valid/ready        dvm, edge_error
//   apb      in   psel/penable       diffusion_scale at byte 0
//
// a compute transaction runs from cmd accept through the queue register, then 19
// weight/voltage reads one pair per cycle from the single-port stores, two pipeline
// stages, one drain check, the scale steps (three slices, one sum, one check) and the output
// the back end takes no new command until a compute is done; a write is taken in idle,
// an edge cell goes straight to the output state
// after reset the voltage store is cleared one cell per cycle, all 32768 cells, with cmd.ready low
// the result register lets the back end finish the next item while res is stalled
`timescale 1ns / 1ps

module stencil19_diffusion_update #(
  parameter int GRID_DIM = 32
) (
  input  logic        clk,
  input  logic        rst,
  s19d_cmd_if.sink    cmd,
  s19d_res_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0]    diffusion_scale;
  logic           clearing;
  logic           fq_valid, fq_ready, bq_valid, bq_ready;
  s19d_pkg::cmd_t fq_data, bq_data;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : diffusion_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      diffusion_scale <= 32'h01000000;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      diffusion_scale <= pwdata;
    end
  end

  s19d_front #(.GRID_DIM(GRID_DIM)) u_front (
    .cmd      (cmd),
    .clearing (clearing),
    .q_ready  (fq_ready),
    .q_valid  (fq_valid),
    .q_data   (fq_data)
  );

  s19d_cmdq u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (bq_valid),
    .out_ready (bq_ready),
    .out_data  (bq_data)
  );

  s19d_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (bq_valid),
    .q_ready  (bq_ready),
    .q_data   (bq_data),
    .scale    (diffusion_scale),
    .clearing (clearing),
    .res      (res)
  );

endmodule

@@ rtl/s19d_checker.sv @@
// port-level checks for the stencil block and their binding
`timescale 1ns / 1ps

module s19d_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] res_dvm,
  input logic        res_edge,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic        pready,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  // store clearing keeps commands out right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !cmd_ready)
    else $error("cmd ready during store clear");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_dvm) && $stable(res_edge))
    else $error("stalled result changed");

  a_edge_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_edge |-> res_dvm == 32'd0)
    else $error("edge result not zero");

  a_scale_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr == 3'd0 |=>
      !(psel && !pwrite && paddr == 3'd0) || prdata == $past(pwdata))
    else $error("scale readback mismatch");

endmodule

bind stencil19_diffusion_update s19d_checker u_s19d_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_ready (cmd.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_dvm   (res.dvm),
  .res_edge  (res.edge_error),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .pready    (pready),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
